>>> hw/rtl/ps2_keyboard_frame_decoder_defines.svh
// Assertion macros shared by the PS/2 keyboard frame decoder RTL.
// Pulled in by the modules that carry concurrent checks; no other dependencies.
`ifndef PS2_KEYBOARD_FRAME_DECODER_DEFINES_SVH
`define PS2_KEYBOARD_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PKBD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pkbd check failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define PKBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pkbd check failed: next-cycle implication");

`endif

>>> hw/rtl/pkbd_pkg.sv
// Shared types, constants and the scan code translation ROM of the PS/2 frame decoder.
// No dependencies; imported by every module of the block.
package pkbd_pkg;

  localparam int FRAME_W   = 11;
  localparam int BYTE_W    = 8;
  localparam int IDX_W     = 7;
  localparam int BANK_W    = 2;
  localparam int ROM_SIZE  = 104;
  localparam int TABLE_ENTRIES_DEFAULT = 104;

  // Frame framing: start bit low, stop bit high
  localparam logic [FRAME_W-1:0] FRAME_MASK  = 11'h401;
  localparam logic [FRAME_W-1:0] FRAME_GOOD  = 11'h400;

  localparam logic [BYTE_W-1:0] BYTE_EXT     = 8'hE0;
  localparam logic [BYTE_W-1:0] BYTE_PAUSE   = 8'hE1;
  localparam logic [BYTE_W-1:0] BYTE_BREAK   = 8'hF0;
  localparam logic [BYTE_W-1:0] BYTE_KBD_ERR = 8'hFC;
  localparam logic [BYTE_W-1:0] BYTE_BAT_OK  = 8'hAA;
  localparam logic [BYTE_W-1:0] BYTE_NULL    = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ERR_OUT = 8'hFF;

  localparam logic [BYTE_W-1:0] GROUP_MASK   = 8'hF0;
  localparam logic [BYTE_W-1:0] BANK_MASK    = 8'h0F;
  localparam logic [BYTE_W-1:0] GROUP_BASE   = 8'h00;
  localparam logic [BYTE_W-1:0] GROUP_EXT    = 8'h10;
  localparam logic [BYTE_W-1:0] GROUP_PAUSE  = 8'h20;

  typedef enum logic [2:0] {
    EV_IGNORED = 3'd0,
    EV_PREFIX  = 3'd1,
    EV_PRESS   = 3'd2,
    EV_RELEASE = 3'd3,
    EV_ERROR   = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic ext;
    logic pause;
    logic brk;
  } prefix_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0]  index;
    logic [BANK_W-1:0] bank;
  } lookup_t;

  typedef struct packed {
    logic              frame_error;
    logic [BYTE_W-1:0] scan_byte;
    event_kind_t       event_kind;
    logic [IDX_W-1:0]  entry_index;
    logic [BANK_W-1:0] key_bank;
    logic              press_flag;
    logic              release_flag;
  } result_t;

  localparam logic [BYTE_W-1:0] ROM_CODE [ROM_SIZE] = '{
    8'h4E,8'h55,8'h5D,8'h66,8'h5A,8'h4A,8'h0E,8'h0D,8'h58,8'h76,8'h12,8'h14,8'h11,8'h59,8'h29,
    8'h1C,8'h32,8'h21,8'h23,8'h24,8'h2B,8'h34,8'h33,8'h43,8'h3B,8'h42,8'h4B,8'h3A,8'h31,8'h44,
    8'h4D,8'h15,8'h2D,8'h1B,8'h2C,8'h3C,8'h2A,8'h1D,8'h22,8'h35,8'h1A,8'h54,8'h5B,8'h4C,8'h52,
    8'h41,8'h49,
    8'h45,8'h16,8'h1E,8'h26,8'h25,8'h2E,8'h36,8'h3D,8'h3E,8'h46,
    8'h70,8'h69,8'h72,8'h7A,8'h6B,8'h73,8'h74,8'h6C,8'h75,8'h7D,8'h77,8'h7C,8'h7B,8'h79,8'h71,
    8'h7E,
    8'h05,8'h06,8'h04,8'h0C,8'h03,8'h0B,8'h83,8'h0A,8'h01,8'h09,8'h78,8'h07,
    8'h1F,8'h14,8'h11,8'h27,8'h2F,
    8'h7C,8'h4A,8'h5A,8'h75,8'h72,8'h74,8'h6B,8'h71,8'h69,8'h7A,8'h7D,8'h6C,8'h70,
    8'h14
  };

  localparam logic [BYTE_W-1:0] ROM_BANK [ROM_SIZE] = '{
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,
    8'h02,
    8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,
    8'h11,8'h11,8'h11,8'h11,8'h11,
    8'h12,8'h12,8'h12,8'h12,8'h12,8'h12,8'h12,8'h12,8'h12,8'h12,8'h12,8'h12,8'h12,
    8'h22
  };

endpackage

>>> hw/rtl/pkbd_frame_check.sv
// Framing and odd-parity check of one raw PS/2 frame; extracts the data byte.
// Depends on pkbd_pkg.
module pkbd_frame_check
  import pkbd_pkg::*;
(
  input  logic [FRAME_W-1:0] frame_bits,
  output logic               frame_error,
  output logic [BYTE_W-1:0]  data_byte
);

  logic framing_ok;
  logic parity_ok;

  assign data_byte  = frame_bits[BYTE_W:1];
  assign framing_ok = (frame_bits & FRAME_MASK) == FRAME_GOOD;
  // data plus parity must carry an odd number of ones
  assign parity_ok  = ^frame_bits[BYTE_W+1:1];
  assign frame_error = !(framing_ok && parity_ok);

endmodule

>>> hw/rtl/pkbd_key_lookup.sv
// Priority match of a scan code against the translation ROM within the active group.
// Depends on pkbd_pkg.
module pkbd_key_lookup
  import pkbd_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
)
(
  input  logic [BYTE_W-1:0] data_byte,
  input  prefix_t           pfx,
  output lookup_t           lk
);

  localparam int SEARCH = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;

  logic [BYTE_W-1:0] group;

  always_comb begin
    group = GROUP_BASE;
    if (pfx.ext) group = GROUP_EXT;
    if (pfx.pause) group = GROUP_PAUSE;
  end

  // Walk from the top down so the lowest matching entry wins
  always_comb begin
    lk = '0;
    for (int i = SEARCH - 1; i >= 0; i--) begin
      if (((ROM_BANK[i] & GROUP_MASK) == group) && (ROM_CODE[i] == data_byte)) begin
        lk.hit   = 1'b1;
        lk.index = IDX_W'(i);
        lk.bank  = BANK_W'(ROM_BANK[i] & BANK_MASK);
      end
    end
  end

endmodule

>>> hw/rtl/pkbd_key_state.sv
// Prefix, pressed-key and status flag state with the event decode for one frame.
// Depends on pkbd_pkg and ps2_keyboard_frame_decoder_defines.svh.
`include "ps2_keyboard_frame_decoder_defines.svh"

module pkbd_key_state
  import pkbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              frame_error,
  input  logic [BYTE_W-1:0] data_byte,
  input  lookup_t           lk,
  output prefix_t           pfx,
  output result_t           res
);

  prefix_t             pfx_next;
  logic [ROM_SIZE-1:0] key_bits;
  logic [ROM_SIZE-1:0] key_bits_next;
  logic                last_press;
  logic                last_press_next;
  logic                last_release;
  logic                last_release_next;
  logic                press;

  always_comb begin
    pfx_next          = pfx;
    key_bits_next     = key_bits;
    last_press_next   = last_press;
    last_release_next = last_release;
    press             = !pfx.brk;

    res.frame_error = frame_error;
    res.scan_byte   = frame_error ? BYTE_ERR_OUT : data_byte;
    res.event_kind  = EV_IGNORED;
    res.entry_index = '0;
    res.key_bank    = '0;

    if (frame_error || (data_byte >= BYTE_KBD_ERR)) begin
      // drop every key, prefix and flag
      pfx_next          = '0;
      key_bits_next     = '0;
      last_press_next   = 1'b0;
      last_release_next = 1'b0;
      res.event_kind    = EV_ERROR;
    end else if ((data_byte == BYTE_NULL) || (data_byte == BYTE_BAT_OK)) begin
      res.event_kind = EV_IGNORED;
    end else if (data_byte == BYTE_PAUSE) begin
      pfx_next.pause = 1'b1;
      res.event_kind = EV_PREFIX;
    end else if (data_byte == BYTE_EXT) begin
      pfx_next.ext   = 1'b1;
      res.event_kind = EV_PREFIX;
    end else if (data_byte == BYTE_BREAK) begin
      pfx_next.brk   = 1'b1;
      res.event_kind = EV_PREFIX;
    end else begin
      if (lk.hit) begin
        key_bits_next[lk.index] = press;
        last_press_next         = press;
        last_release_next       = !press;
        res.event_kind          = press ? EV_PRESS : EV_RELEASE;
        res.entry_index         = lk.index;
        res.key_bank            = lk.bank;
      end
      // consume prefixes; pause survives until its break sequence ends
      pfx_next.ext = 1'b0;
      if (pfx.brk) pfx_next.pause = 1'b0;
      pfx_next.brk = 1'b0;
    end

    res.press_flag   = last_press_next;
    res.release_flag = last_release_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pfx          <= '0;
      key_bits     <= '0;
      last_press   <= 1'b0;
      last_release <= 1'b0;
    end else if (advance) begin
      pfx          <= pfx_next;
      key_bits     <= key_bits_next;
      last_press   <= last_press_next;
      last_release <= last_release_next;
    end
  end

  `PKBD_ASSERT_NOW(a_flags_exclusive, clk, rst, 1'b1, !(last_press && last_release))
  `PKBD_ASSERT_NEXT(a_error_clears, clk, rst, advance && res.event_kind == EV_ERROR, key_bits == '0 && pfx == '0 && !last_press && !last_release)
  `PKBD_ASSERT_NEXT(a_press_sets_key, clk, rst, advance && res.event_kind == EV_PRESS, key_bits[$past(res.entry_index)] && last_press)
  `PKBD_ASSERT_NEXT(a_key_eats_prefix, clk, rst, advance && (res.event_kind == EV_PRESS || res.event_kind == EV_RELEASE), !pfx.ext && !pfx.brk)

endmodule

>>> hw/rtl/ps2_keyboard_frame_decoder.sv
// A word taken into the input register moves to the result register and shows on the master side once that is free.
// Throughput: one frame per cycle while m_tready is high. A result held by the master side
// stalls the input register, and s_tready drops once the input register is also full.
// The ROM match, prefix and flag update run combinationally between those registers.
// Reset (rst, synchronous): both registers empty, prefixes, pressed keys and flags clear.
module ps2_keyboard_frame_decoder
  import pkbd_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [10:0] frame_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] scan_byte, [14:8] entry_index, [16:15] key_bank,
                                 // [17] press_flag, [18] release_flag
  output logic [3:0]  m_tuser    // [0] frame_error, [3:1] event_kind
);

  logic               in_valid;
  logic [FRAME_W-1:0] in_frame;
  logic               out_valid;
  result_t            out_res;
  logic               advance;
  logic               frm_err;
  logic [BYTE_W-1:0]  data_byte;
  prefix_t            pfx;
  lookup_t            lk;
  result_t            res;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // hold the frame word until it moves to the result register
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_frame <= s_tdata[FRAME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  pkbd_frame_check u_check (
    .frame_bits  (in_frame),
    .frame_error (frm_err),
    .data_byte   (data_byte)
  );

  pkbd_key_lookup #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_lookup (
    .data_byte (data_byte),
    .pfx       (pfx),
    .lk        (lk)
  );

  pkbd_key_state u_state (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .frame_error (frm_err),
    .data_byte   (data_byte),
    .lk          (lk),
    .pfx         (pfx),
    .res         (res)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_res.release_flag, out_res.press_flag, out_res.key_bank,
                     out_res.entry_index, out_res.scan_byte};
  assign m_tuser  = {out_res.event_kind, out_res.frame_error};

endmodule
